/* rtl/dda_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dda_pkg
// Shared types and constants of the DDA line pixel rasterizer.
// ----------------------------------------------------------------------------
package dda_pkg;

  // request opcode
  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_t;

  // configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_BASE     = 2'd0,
    CFG_ROW_BYTES      = 2'd1,
    CFG_BITS_PER_PIXEL = 2'd2,
    CFG_UNUSED         = 2'd3
  } cfg_idx_t;

  // fixed field widths
  localparam int ADDR_W   = 32;
  localparam int COLOR_W  = 32;
  localparam int STRIDE_W = 16;
  localparam int BPP_W    = 6;

  // bits_per_pixel after reset
  localparam logic [BPP_W-1:0] BPP_RESET = 6'd32;

endpackage : dda_pkg
`default_nettype wire

/* rtl/dda_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dda_in_if / dda_out_if
// Valid/ready channels for line requests and emitted pixels.
// ----------------------------------------------------------------------------
interface dda_in_if import dda_pkg::*; #(
  parameter int COORD_BITS = 12
) ();
  logic                  valid;
  logic                  ready;
  op_t                   op;
  logic [COORD_BITS-1:0] start_x;
  logic [COORD_BITS-1:0] start_y;
  logic [COORD_BITS-1:0] end_x;
  logic [COORD_BITS-1:0] end_y;
  logic [COLOR_W-1:0]    color;

  modport source (output valid, op, start_x, start_y, end_x, end_y, color,
                  input ready);
  modport sink   (input valid, op, start_x, start_y, end_x, end_y, color,
                  output ready);
endinterface : dda_in_if

interface dda_out_if import dda_pkg::*; #(
  parameter int COORD_BITS = 12
) ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  logic [ADDR_W-1:0]     byte_address;
  logic [COLOR_W-1:0]    pixel_value;
  logic                  last;

  modport source (output valid, pixel_x, pixel_y, byte_address, pixel_value, last,
                  input ready);
  modport sink   (input valid, pixel_x, pixel_y, byte_address, pixel_value, last,
                  output ready);
endinterface : dda_out_if
`default_nettype wire

/* rtl/dda_sub.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dda_sub
// Shared subtract/compare unit: one trial subtraction per cycle for the
// restoring square root and the restoring divider.
// ----------------------------------------------------------------------------
module dda_sub #(
  parameter int W = 15
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic [W-1:0] diff,
  output logic         ge
);

  logic [W:0] full;

  // borrow out of the top bit means a < b
  assign full = {1'b0, a} - {1'b0, b};
  assign diff = full[W-1:0];
  assign ge   = ~full[W];

endmodule : dda_sub
`default_nettype wire

/* rtl/dda_line_pixel_rasterizer.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dda_line_pixel_rasterizer
// DDA line rasterizer: a start request computes the pixel count and the
// fixed-point per-pixel increments; each step request while a line is active
// emits one pixel with its frame buffer byte address.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake        Payload
//  in_ch    in   valid/ready      op, start_x, start_y, end_x, end_y, color
//  out_ch   out  valid/ready      pixel_x, pixel_y, byte_address, pixel_value, last
//  cfg_*    in   write enable     cfg_index, cfg_data (image_base, row_bytes, bpp)
//
//  Start request: squaring of both deltas, root iterations, then divide
//  iterations for x and then y (a zero length line skips the divides); root
//  and divide iterations share the one subtractor. Step request: round,
//  then address multiply. in_ch.ready is high only between requests;
//  a pixel waits in the output register and holds the address stage while
//  out_ch.ready is low. Reset (rst_n, synchronous) leaves no line active.
// ----------------------------------------------------------------------------
module dda_line_pixel_rasterizer import dda_pkg::*; #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  dda_in_if.sink                in_ch,
  dda_out_if.source             out_ch
);

  localparam int C      = COORD_BITS;
  localparam int F      = FRAC_BITS;
  localparam int PW     = C + F;          // position width
  localparam int RW     = 2 * C + 2;      // radicand width
  localparam int W      = C + 3;          // shared unit width
  localparam int QW     = F + 1;          // quotient width
  localparam int IW     = F + 2;          // signed increment width
  localparam int N_ROOT = C + 1;
  localparam int N_DIV  = C + F;
  localparam int CNT_W  = $clog2(N_DIV + 1);
  localparam logic [PW:0]      HALF     = (PW+1)'(1) << (F - 1);
  localparam logic [CNT_W-1:0] ROOT_END = CNT_W'(N_ROOT - 1);
  localparam logic [CNT_W-1:0] DIV_END  = CNT_W'(N_DIV - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQX,
    S_SQY,
    S_ROOT,
    S_DIVX,
    S_DIVY,
    S_ADDR
  } state_t;

  state_t            state_r;
  logic [PW-1:0]     pos_x_r, pos_y_r;
  logic [IW-1:0]     inc_x_r, inc_y_r;
  logic [C:0]        remaining_r;
  logic [COLOR_W-1:0] color_r;
  logic [C-1:0]      adx_r, ady_r;
  logic              neg_x_r, neg_y_r;
  logic [RW-1:0]     rad_r;
  logic [W-1:0]      rem_r;
  logic [C:0]        root_r;
  logic [PW-1:0]     dvd_r;
  logic [QW-1:0]     quo_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [C-1:0]      px_r, py_r;
  logic              last_r;

  logic [ADDR_W-1:0]   base_r;
  logic [STRIDE_W-1:0] row_bytes_r;
  logic [BPP_W-1:0]    bpp_r;

  logic                out_valid_r;
  logic [C-1:0]        out_x_r, out_y_r;
  logic [ADDR_W-1:0]   out_addr_r;
  logic [COLOR_W-1:0]  out_color_r;
  logic                out_last_r;

  // request handshake
  logic in_fire;
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid & in_ch.ready;

  // endpoint deltas as magnitude and sign
  logic [C:0] dx_raw, dy_raw, dx_mag, dy_mag;
  assign dx_raw = {1'b0, in_ch.end_x} - {1'b0, in_ch.start_x};
  assign dy_raw = {1'b0, in_ch.end_y} - {1'b0, in_ch.start_y};
  assign dx_mag = dx_raw[C] ? -dx_raw : dx_raw;
  assign dy_mag = dy_raw[C] ? -dy_raw : dy_raw;

  // squaring multiplier, one delta per cycle
  logic [C-1:0]   mul_op;
  logic [2*C-1:0] prod;
  assign mul_op = (state_r == S_SQX) ? adx_r : ady_r;
  assign prod   = mul_op * mul_op;

  // shared subtractor operands: root trial or divisor
  logic [W-1:0] sub_a, sub_b, sub_diff;
  logic         sub_ge;
  always_comb begin
    if (state_r == S_ROOT) begin
      sub_a = {rem_r[W-3:0], rad_r[RW-1 -: 2]};
      sub_b = {root_r, 2'b01};
    end else begin
      sub_a = {rem_r[W-2:0], dvd_r[PW-1]};
      sub_b = W'(remaining_r);
    end
  end

  dda_sub #(.W(W)) u_sub (
    .a    (sub_a),
    .b    (sub_b),
    .diff (sub_diff),
    .ge   (sub_ge)
  );

  logic [C:0]    root_nxt;
  logic [QW-1:0] quo_nxt;
  logic [IW-1:0] quo_s;
  assign root_nxt = {root_r[C-1:0], sub_ge};
  assign quo_nxt  = {quo_r[QW-2:0], sub_ge};
  assign quo_s    = {1'b0, quo_nxt};

  // rounding of the current position (position is never negative)
  logic [PW:0] rnd_x, rnd_y;
  assign rnd_x = {1'b0, pos_x_r} + HALF;
  assign rnd_y = {1'b0, pos_y_r} + HALF;

  // position advance
  logic [PW-1:0] pos_x_nxt, pos_y_nxt;
  assign pos_x_nxt = pos_x_r + {{(PW-IW){inc_x_r[IW-1]}}, inc_x_r};
  assign pos_y_nxt = pos_y_r + {{(PW-IW){inc_y_r[IW-1]}}, inc_y_r};

  // byte address
  logic [C+STRIDE_W-1:0] row_off;
  logic [C+2:0]          col_off;
  logic [ADDR_W-1:0]     addr;
  assign row_off = py_r * row_bytes_r;
  assign col_off = px_r * bpp_r[BPP_W-1:3];
  assign addr    = base_r + ADDR_W'(row_off) + ADDR_W'(col_off);

  logic out_free;
  logic out_load;
  assign out_free = ~out_valid_r | out_ch.ready;
  assign out_load = (state_r == S_ADDR) & out_free;

  // sequencer, datapath and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      remaining_r <= '0;
      out_valid_r <= 1'b0;
      base_r      <= '0;
      row_bytes_r <= '0;
      bpp_r       <= BPP_RESET;
    end else begin
      // configuration writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_IMAGE_BASE:     base_r      <= cfg_data[ADDR_W-1:0];
          CFG_ROW_BYTES:      row_bytes_r <= cfg_data[STRIDE_W-1:0];
          CFG_BITS_PER_PIXEL: bpp_r       <= cfg_data[BPP_W-1:0];
          default: ;
        endcase
      end

      // output register: load a new pixel or drain the held one
      if (out_load) begin
        out_valid_r <= 1'b1;
        out_x_r     <= px_r;
        out_y_r     <= py_r;
        out_addr_r  <= addr;
        out_color_r <= color_r;
        out_last_r  <= last_r;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_fire && in_ch.op == OP_START) begin
            pos_x_r <= {in_ch.start_x, {F{1'b0}}};
            pos_y_r <= {in_ch.start_y, {F{1'b0}}};
            adx_r   <= dx_mag[C-1:0];
            ady_r   <= dy_mag[C-1:0];
            neg_x_r <= dx_raw[C];
            neg_y_r <= dy_raw[C];
            color_r <= in_ch.color;
            state_r <= S_SQX;
          end else if (in_fire && remaining_r != '0) begin
            px_r        <= rnd_x[PW-1:F];
            py_r        <= rnd_y[PW-1:F];
            last_r      <= (remaining_r == (C+1)'(1));
            pos_x_r     <= pos_x_nxt;
            pos_y_r     <= pos_y_nxt;
            remaining_r <= remaining_r - (C+1)'(1);
            state_r     <= S_ADDR;
          end
        end
        S_SQX: begin
          rad_r   <= RW'(prod);
          state_r <= S_SQY;
        end
        S_SQY: begin
          rad_r   <= rad_r + RW'(prod);
          rem_r   <= '0;
          root_r  <= '0;
          cnt_r   <= '0;
          state_r <= S_ROOT;
        end
        S_ROOT: begin
          // one root bit per cycle
          root_r <= root_nxt;
          rad_r  <= rad_r << 2;
          if (cnt_r == ROOT_END) begin
            remaining_r <= root_nxt;
            rem_r       <= '0;
            quo_r       <= '0;
            cnt_r       <= '0;
            dvd_r       <= {adx_r, {F{1'b0}}};
            if (root_nxt == '0) begin
              inc_x_r <= '0;
              inc_y_r <= '0;
              state_r <= S_IDLE;
            end else begin
              state_r <= S_DIVX;
            end
          end else begin
            rem_r <= sub_ge ? sub_diff : sub_a;
            cnt_r <= cnt_r + CNT_W'(1);
          end
        end
        S_DIVX, S_DIVY: begin
          // one quotient bit per cycle
          if (cnt_r == DIV_END) begin
            rem_r <= '0;
            quo_r <= '0;
            cnt_r <= '0;
            if (state_r == S_DIVX) begin
              inc_x_r <= neg_x_r ? -quo_s : quo_s;
              dvd_r   <= {ady_r, {F{1'b0}}};
              state_r <= S_DIVY;
            end else begin
              inc_y_r <= neg_y_r ? -quo_s : quo_s;
              state_r <= S_IDLE;
            end
          end else begin
            rem_r <= sub_ge ? sub_diff : sub_a;
            quo_r <= quo_nxt;
            dvd_r <= dvd_r << 1;
            cnt_r <= cnt_r + CNT_W'(1);
          end
        end
        S_ADDR: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // result channel
  assign out_ch.valid        = out_valid_r;
  assign out_ch.pixel_x      = out_x_r;
  assign out_ch.pixel_y      = out_y_r;
  assign out_ch.byte_address = out_addr_r;
  assign out_ch.pixel_value  = out_color_r;
  assign out_ch.last         = out_last_r;

endmodule : dda_line_pixel_rasterizer
`default_nettype wire
